// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define WSD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define WSD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wsd_pkg.sv =====
// Package for the websocket frame deframer: result kinds, parser constants,
// queue sizing and the word type passed from parser to result sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [2:0] LEN16_LAST = 3'd1;
    localparam logic [2:0] LEN64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        has_main;
        logic [1:0]  kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [7:0]  data_byte;
        logic        last_of_frame;
        logic        has_err;
    } wsd_word_t;

endpackage

`default_nettype wire

// ===== hdl/websocket_frame_deframer_unit.sv =====
// Channel   Handshake           Word
// input     push / full         in_byte, end_of_buffer
// result    pop / empty         kind, fin, opcode, masked, payload_length,
//                               data_byte, last_of_frame
// One input byte is taken per cycle while full is low; the parser updates its
// state in that cycle. A result passes through the word queue and then the
// sequencer's output register before it reaches the ports. A byte that ends
// a truncated frame and has a result of its own yields two results and occupies
// the output stage for two pops. The word queue holds four words; full rises
// when results are taken too slowly. Reset empties the queue; no clearing pass.
//
// Top level of the websocket frame deframer: parser, word queue, result
// sequencer. Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_deframer_unit
    import wsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_buffer,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       kind,
    output logic             fin,
    output logic [3:0]       opcode,
    output logic             masked,
    output logic [63:0]      payload_length,
    output logic [7:0]       data_byte,
    output logic             last_of_frame
);

    logic      accept;
    logic      word_push;
    wsd_word_t front_word;
    wsd_word_t head_word;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    wsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .word_push     (word_push),
        .word          (front_word)
    );

    wsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (word_push),
        .wr_word (front_word),
        .rd_en   (q_pop),
        .rd_word (head_word),
        .q_full  (q_full),
        .q_valid (q_valid)
    );

    wsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_word         (head_word),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .fin            (fin),
        .opcode         (opcode),
        .masked         (masked),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .last_of_frame  (last_of_frame)
    );

    `WSD_ASSERT_IMPLIES(a_push_has_result, word_push, front_word.has_main || front_word.has_err, "queued word carries no result")
    `WSD_ASSERT_IMPLIES(a_no_push_when_full, word_push, !q_full, "word queued while queue full")
    `WSD_ASSERT_IMPLIES(a_error_zero, !empty && kind == KIND_ERROR, !fin && opcode == 4'd0 && !masked && payload_length == 64'd0 && data_byte == 8'd0 && !last_of_frame, "error result carries frame fields")
    `WSD_ASSERT_IMPLIES(a_empty_frame_len, !empty && kind == KIND_HEADER && last_of_frame, payload_length == 64'd0, "closing header with nonzero length")

endmodule

`default_nettype wire

// ===== hdl/wsd_front.sv =====
// Frame parser: walks the header fields, unmasks payload bytes and builds
// one word per input byte that causes results. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_front
    import wsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire logic [7:0] in_byte,
    input  wire logic      end_of_buffer,
    output logic           word_push,
    output wsd_word_t      word
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_LEN16,
        PH_LEN64,
        PH_KEY,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic [63:0] rem_reg, rem_next;

    logic        len_done;
    logic        emit;
    logic        last_pay;
    logic [7:0]  key_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        rem_next    = rem_reg;
        len_done    = 1'b0;
        emit        = 1'b0;
        last_pay    = (rem_reg == 64'd1);
        key_byte    = masked_reg ? key_reg[{~kidx_reg, 3'b000} +: 8] : 8'h00;
        word        = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    masked_next = in_byte[7];
                    cnt_next    = '0;
                    if (in_byte[6:0] == LEN_CODE_16)
                    begin
                        len_next   = '0;
                        phase_next = PH_LEN16;
                    end
                    else if (in_byte[6:0] == LEN_CODE_64)
                    begin
                        len_next   = '0;
                        phase_next = PH_LEN64;
                    end
                    else
                    begin
                        len_next = {57'd0, in_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_LEN16:
                begin
                    len_next = {len_reg[55:0], in_byte};
                    if (cnt_reg >= LEN16_LAST)
                        len_done = 1'b1;
                    else
                        cnt_next = cnt_reg + 3'd1;
                end
                PH_LEN64:
                begin
                    len_next = {len_reg[55:0], in_byte};
                    if (cnt_reg >= LEN64_LAST)
                        len_done = 1'b1;
                    else
                        cnt_next = cnt_reg + 3'd1;
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (cnt_reg >= KEY_LAST)
                        emit = 1'b1;
                    else
                        cnt_next = cnt_reg + 3'd1;
                end
                PH_PAYLOAD:
                begin
                    kidx_next          = kidx_reg + 2'd1;
                    rem_next           = rem_reg - 64'd1;
                    word.has_main      = 1'b1;
                    word.kind          = KIND_PAYLOAD;
                    word.data_byte     = in_byte ^ key_byte;
                    word.last_of_frame = last_pay;
                    if (last_pay)
                        phase_next = PH_DISCARD;
                end
                PH_DISCARD:
                begin
                    phase_next = PH_DISCARD;
                end
                default:
                begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    masked_next = 1'b0;
                    len_next    = '0;
                    key_next    = '0;
                    kidx_next   = '0;
                    rem_next    = '0;
                    cnt_next    = '0;
                    phase_next  = PH_HDR1;
                end
            endcase

            // go to the key or straight to the header result
            if (len_done)
            begin
                if (masked_next)
                begin
                    phase_next = PH_KEY;
                    cnt_next   = '0;
                    key_next   = '0;
                end
                else
                    emit = 1'b1;
            end

            if (emit)
            begin
                word.has_main      = 1'b1;
                word.kind          = KIND_HEADER;
                word.last_of_frame = (len_next == 64'd0);
                rem_next           = len_next;
                kidx_next          = '0;
                phase_next         = (len_next == 64'd0) ? PH_DISCARD : PH_PAYLOAD;
            end

            word.fin            = fin_next;
            word.opcode         = opcode_next;
            word.masked         = masked_next;
            word.payload_length = len_next;

            // flag an unfinished frame and rearm for the next buffer
            if (end_of_buffer)
            begin
                word.has_err = (phase_next != PH_DISCARD);
                phase_next   = PH_HDR0;
                cnt_next     = '0;
            end
        end
    end

    assign word_push = accept && (word.has_main || word.has_err);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            key_reg    <= '0;
            kidx_reg   <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            rem_reg    <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wsd_queue.sv =====
// Short word queue between the parser and the result sequencer.
// Depends on wsd_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue
    import wsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire wsd_word_t wr_word,
    input  wire logic      rd_en,
    output wsd_word_t      rd_word,
    output logic           q_full,
    output logic           q_valid
);

    wsd_word_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg, count_next;

    assign q_full  = (count_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign q_valid = (count_reg != '0);
    assign rd_word = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wsd_back.sv =====
// Result sequencer: holds the current word and presents its main result, if any,
// then its error result when flagged. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_back
    import wsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire wsd_word_t q_word,
    output logic           q_pop,
    input  wire logic      pop,
    output logic           empty,
    output logic [1:0]     kind,
    output logic           fin,
    output logic [3:0]     opcode,
    output logic           masked,
    output logic [63:0]    payload_length,
    output logic [7:0]     data_byte,
    output logic           last_of_frame
);

    wsd_word_t cur_reg;
    logic      valid_reg;
    logic      show_err_reg;
    logic      finishing;
    logic      free_slot;

    assign finishing = valid_reg && pop && (show_err_reg || !cur_reg.has_err);
    assign free_slot = !valid_reg || finishing;
    assign q_pop     = q_valid && free_slot;
    assign empty     = !valid_reg;

    always_comb
    begin
        if (show_err_reg)
        begin
            kind           = KIND_ERROR;
            fin            = 1'b0;
            opcode         = '0;
            masked         = 1'b0;
            payload_length = '0;
            data_byte      = '0;
            last_of_frame  = 1'b0;
        end
        else
        begin
            kind           = cur_reg.kind;
            fin            = cur_reg.fin;
            opcode         = cur_reg.opcode;
            masked         = cur_reg.masked;
            payload_length = cur_reg.payload_length;
            data_byte      = cur_reg.data_byte;
            last_of_frame  = cur_reg.last_of_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            show_err_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg    <= 1'b1;
            show_err_reg <= !q_word.has_main;
        end
        else if (finishing)
        begin
            valid_reg    <= 1'b0;
            show_err_reg <= 1'b0;
        end
        else if (valid_reg && pop)
        begin
            // advance from the main result to the error result
            show_err_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire
